@@ src/jdrh_pkg.sv @@
// shared constants and widths for the job deadline response histogram
`timescale 1ns / 1ps
`default_nettype none
package jdrh_pkg;

  localparam int TIME_W = 64;
  localparam int US_W   = 55;
  localparam int CNT_W  = 32;
  localparam int JOB_W  = 32;
  localparam int IDX_W  = 10;
  localparam int CFG_W  = 3;

  localparam logic [CFG_W-1:0] CFG_PERIOD    = 3'd0;
  localparam logic [CFG_W-1:0] CFG_REL_DL    = 3'd1;
  localparam logic [CFG_W-1:0] CFG_START_REF = 3'd2;
  localparam logic [CFG_W-1:0] CFG_OFFSET    = 3'd3;
  localparam logic [CFG_W-1:0] CFG_FIRST_JOB = 3'd4;

  localparam logic       CMD_RECORD = 1'b0;
  localparam logic       CMD_READ   = 1'b1;

  localparam logic [10:0] NS_PER_US  = 11'd1000;
  localparam logic [64:0] HALF_US_NS = 65'd500;
  // 2^30 / 125 rounded up, exact for quotients below 2^16
  localparam logic [23:0] RECIP_125  = 24'd8589935;

  typedef logic [TIME_W-1:0] time_ns_t;
  typedef logic [US_W-1:0]   time_us_t;
  typedef logic [CNT_W-1:0]  count_t;

endpackage
`default_nettype wire

@@ src/jdrh_timing.sv @@
// release, deadline and rounded response time of one job, multi-cycle
`timescale 1ns / 1ps
`default_nettype none
module jdrh_timing (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   go,
  input  wire [32:0]            mult,
  input  jdrh_pkg::time_ns_t    period_ns,
  input  jdrh_pkg::time_ns_t    offset_ns,
  input  jdrh_pkg::time_ns_t    rel_deadline_ns,
  input  jdrh_pkg::time_ns_t    start_ref_ns,
  input  jdrh_pkg::time_ns_t    finish_ns,
  output logic                  done,
  output logic                  late,
  output jdrh_pkg::time_us_t    resp_us
);

  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_MUL  = 3'd1;
  localparam logic [2:0] T_REL  = 3'd2;
  localparam logic [2:0] T_DL   = 3'd3;
  localparam logic [2:0] T_CMP  = 3'd4;
  localparam logic [2:0] T_RND  = 3'd5;
  localparam logic [2:0] T_DIV  = 3'd6;
  localparam logic [2:0] T_SUB  = 3'd7;

  logic [2:0]          state;
  jdrh_pkg::time_ns_t  acc;
  logic [32:0]         mreg;
  logic [5:0]          bitcnt;
  jdrh_pkg::time_ns_t  release_ns;
  jdrh_pkg::time_ns_t  deadline_ns;
  jdrh_pkg::time_ns_t  frel;
  logic                fge;
  jdrh_pkg::time_ns_t  resp_ns;
  logic [79:0]         xdiv;
  logic [9:0]          rem;
  logic [2:0]          dcnt;
  logic [15:0]         qd;
  logic [25:0]         dvr;

  logic [64:0] mul_sum;
  logic [64:0] rel_sum;
  logic [64:0] dl_sum;
  logic [64:0] fdiff;
  logic [25:0] dv;
  logic [46:0] qprod;
  logic [25:0] qback;
  logic [25:0] rdiff;

  always_comb begin
    mul_sum = {1'b0, acc[62:0], 1'b0} + {1'b0, (mreg[32] ? period_ns : 64'd0)};
    rel_sum = {1'b0, offset_ns} + {1'b0, acc};
    dl_sum  = {1'b0, release_ns} + {1'b0, rel_deadline_ns};
    fdiff   = {1'b0, finish_ns} - {1'b0, start_ref_ns};
    // one 16-bit chunk of the divide by 1000: divide by 8, then by 125
    dv      = {rem, xdiv[79:64]};
    qprod   = {24'd0, dv[25:3]} * {23'd0, jdrh_pkg::RECIP_125};
    qback   = {10'd0, qd} * {15'd0, jdrh_pkg::NS_PER_US};
    rdiff   = dvr - qback;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (go) begin
            acc    <= '0;
            mreg   <= mult;
            bitcnt <= 6'd32;
            fge    <= !fdiff[64];
            frel   <= fdiff[63:0];
            state  <= T_MUL;
          end
        end
        T_MUL: begin
          acc    <= (acc[63] || mul_sum[64]) ? '1 : mul_sum[63:0];
          mreg   <= {mreg[31:0], 1'b0};
          bitcnt <= bitcnt - 6'd1;
          if (bitcnt == 6'd0) state <= T_REL;
        end
        T_REL: begin
          release_ns <= rel_sum[64] ? '1 : rel_sum[63:0];
          state      <= T_DL;
        end
        T_DL: begin
          deadline_ns <= dl_sum[64] ? '1 : dl_sum[63:0];
          state       <= T_CMP;
        end
        T_CMP: begin
          late    <= fge && (frel > deadline_ns);
          resp_ns <= (fge && (frel > release_ns)) ? (frel - release_ns) : '0;
          state   <= T_RND;
        end
        T_RND: begin
          xdiv    <= {15'd0, {1'b0, resp_ns} + jdrh_pkg::HALF_US_NS};
          rem     <= '0;
          resp_us <= '0;
          dcnt    <= 3'd5;
          state   <= T_DIV;
        end
        T_DIV: begin
          qd    <= qprod[45:30];
          dvr   <= dv;
          state <= T_SUB;
        end
        T_SUB: begin
          rem     <= rdiff[9:0];
          resp_us <= {resp_us[38:0], qd};
          xdiv    <= {xdiv[63:0], 16'd0};
          dcnt    <= dcnt - 3'd1;
          if (dcnt == 3'd1) begin
            done  <= 1'b1;
            state <= T_IDLE;
          end else begin
            state <= T_DIV;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ src/job_deadline_response_histogram_core.sv @@
// top level: job timing, sorted response table and counters
`timescale 1ns / 1ps
`default_nettype none
// usage
//   an item is taken when start is high and busy is low; cmd selects record
//   (0) or read (1). one result follows per item, shown for a single cycle
//   with done high; the receiver cannot hold it off, so it must sample then.
//   configuration goes through cfg_valid/cfg_ready (always ready) with
//   cfg_index and cfg_data; the user must do so only while busy is low, as
//   the block itself does not enforce it.
// sequence, from the accepting edge to the edge that raises done
//   record: the timing unit runs 33 multiply steps, release, deadline,
//   compare, rounding offset and five divide-by-1000 chunks, then the
//   table pass reads one entry per cycle from the table memory.
//   read: one count read per cycle for the running sum, up to the index;
//   an index at or beyond entries_used answers without a table read.
//   one item at a time; busy stays high until done, and the next item can
//   be taken in the cycle where done is high.
// reset
//   rst clears counters and the table fill count, loads first_job with 1
//   and the period, deadline, reference and offset settings with 0; the memories need no clearing.
module job_deadline_response_histogram_core #(
  parameter int TABLE_DEPTH = 1024,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  input  wire                  cmd,
  input  jdrh_pkg::time_ns_t   start_ns,
  input  jdrh_pkg::time_ns_t   finish_ns,
  input  wire [9:0]            read_index,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [2:0]            cfg_index,
  input  jdrh_pkg::time_ns_t   cfg_data,
  output logic                 done,
  output logic                 is_late,
  output jdrh_pkg::time_us_t   response_us,
  output jdrh_pkg::count_t     late_total,
  output jdrh_pkg::count_t     job_total,
  output logic [CW-1:0]        entries_used,
  output logic                 dropped,
  output jdrh_pkg::time_us_t   entry_value_us,
  output jdrh_pkg::count_t     entry_count,
  output jdrh_pkg::count_t     cumulative_count,
  output logic                 index_valid
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int XW = (CW > jdrh_pkg::IDX_W) ? CW : jdrh_pkg::IDX_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TIME = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_TAIL = 3'd3;
  localparam logic [2:0] S_RSUM = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]          state;
  jdrh_pkg::time_ns_t  period_ns;
  jdrh_pkg::time_ns_t  rel_deadline_ns;
  jdrh_pkg::time_ns_t  start_ref_ns;
  jdrh_pkg::time_ns_t  offset_ns;
  logic [31:0]         first_job;
  logic                rec;
  logic [AW-1:0]       ridx;
  logic [CW-1:0]       rp;
  logic                ev_vld;
  logic [AW-1:0]       ev_idx;
  logic                ins;
  jdrh_pkg::time_us_t  carry_v;
  jdrh_pkg::count_t    carry_c;
  jdrh_pkg::count_t    cum;

  jdrh_pkg::time_us_t  val_mem [TABLE_DEPTH];
  jdrh_pkg::count_t    cnt_mem [TABLE_DEPTH];
  jdrh_pkg::time_us_t  val_q;
  jdrh_pkg::count_t    cnt_q;

  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  jdrh_pkg::time_us_t  mem_wv;
  jdrh_pkg::count_t    mem_wc;

  logic                t_go;
  logic                t_done;
  logic                t_late;
  jdrh_pkg::time_us_t  t_resp;
  logic [32:0]         jobno;
  logic [32:0]         mult;

  logic                full;
  logic                hit;
  logic                gt;
  logic                last;
  logic                issue;
  logic [32:0]         cum_sum;
  jdrh_pkg::count_t    cum_sat;
  jdrh_pkg::count_t    cnt_inc;

  assign busy             = state != S_IDLE;
  assign cfg_ready        = 1'b1;

  always_comb begin
    jobno   = {1'b0, first_job} + {1'b0, job_total};
    mult    = (jobno == 33'd0) ? 33'd0 : jobno - 33'd1;
    t_go    = (state == S_IDLE) && start && (cmd == jdrh_pkg::CMD_RECORD);
    full    = entries_used == CW'(TABLE_DEPTH);
    hit     = val_q == response_us;
    gt      = val_q > response_us;
    last    = (CW'(ev_idx) + CW'(1)) == entries_used;
    issue   = rp < entries_used;
    cum_sum = {1'b0, cum} + {1'b0, cnt_q};
    cum_sat = cum_sum[32] ? '1 : cum_sum[31:0];
    cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 32'd1;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = ev_idx;
    mem_wv = response_us;
    mem_wc = 32'd1;
    unique case (state)
      S_SCAN: begin
        if (ev_vld) begin
          if (ins) begin
            mem_we = 1'b1;
            mem_wv = carry_v;
            mem_wc = carry_c;
          end else if (hit) begin
            mem_we = 1'b1;
            mem_wc = cnt_inc;
          end else if (gt && !full) begin
            mem_we = 1'b1;
          end
        end
      end
      S_TAIL: begin
        mem_wa = entries_used[AW-1:0];
        if (ins) begin
          mem_we = 1'b1;
          mem_wv = carry_v;
          mem_wc = carry_c;
        end else if (!full) begin
          mem_we = 1'b1;
        end
      end
      default: mem_we = 1'b0;
    endcase
  end

  // table memories, at most one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      val_mem[mem_wa] <= mem_wv;
      cnt_mem[mem_wa] <= mem_wc;
    end
    val_q <= val_mem[rp[AW-1:0]];
    cnt_q <= cnt_mem[rp[AW-1:0]];
  end

  jdrh_timing u_timing (
    .clk             (clk),
    .rst             (rst),
    .go              (t_go),
    .mult            (mult),
    .period_ns       (period_ns),
    .offset_ns       (offset_ns),
    .rel_deadline_ns (rel_deadline_ns),
    .start_ref_ns    (start_ref_ns),
    .finish_ns       (finish_ns),
    .done            (t_done),
    .late            (t_late),
    .resp_us         (t_resp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      done            <= 1'b0;
      entries_used    <= '0;
      job_total       <= '0;
      late_total      <= '0;
      period_ns       <= '0;
      rel_deadline_ns <= '0;
      start_ref_ns    <= '0;
      offset_ns       <= '0;
      first_job       <= 32'd1;
      ev_vld          <= 1'b0;
      rp              <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          jdrh_pkg::CFG_PERIOD:    period_ns       <= cfg_data;
          jdrh_pkg::CFG_REL_DL:    rel_deadline_ns <= cfg_data;
          jdrh_pkg::CFG_START_REF: start_ref_ns    <= cfg_data;
          jdrh_pkg::CFG_OFFSET:    offset_ns       <= cfg_data;
          jdrh_pkg::CFG_FIRST_JOB: first_job       <= cfg_data[31:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            is_late          <= 1'b0;
            response_us      <= '0;
            dropped          <= 1'b0;
            entry_value_us   <= '0;
            entry_count      <= '0;
            cumulative_count <= '0;
            index_valid      <= 1'b0;
            rec              <= cmd == jdrh_pkg::CMD_RECORD;
            ridx             <= AW'(read_index);
            rp               <= '0;
            ev_vld           <= 1'b0;
            ins              <= 1'b0;
            cum              <= '0;
            if (cmd == jdrh_pkg::CMD_RECORD) begin
              state <= S_TIME;
            end else if (XW'(read_index) < XW'(entries_used)) begin
              state <= S_RSUM;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_TIME: begin
          if (t_done) begin
            is_late     <= t_late;
            response_us <= t_resp;
            state       <= (entries_used == '0) ? S_TAIL : S_SCAN;
          end
        end
        S_SCAN: begin
          ev_vld <= issue;
          ev_idx <= rp[AW-1:0];
          if (issue) rp <= rp + CW'(1);
          if (ev_vld) begin
            if (ins) begin
              carry_v <= val_q;
              carry_c <= cnt_q;
              if (last) state <= S_TAIL;
            end else if (hit) begin
              state <= S_OUT;
            end else if (gt && full) begin
              dropped <= 1'b1;
              state   <= S_OUT;
            end else begin
              if (gt) begin
                ins     <= 1'b1;
                carry_v <= val_q;
                carry_c <= cnt_q;
              end
              if (last) state <= S_TAIL;
            end
          end
        end
        S_TAIL: begin
          if (ins || !full) begin
            entries_used <= entries_used + CW'(1);
          end else begin
            dropped <= 1'b1;
          end
          state <= S_OUT;
        end
        S_RSUM: begin
          ev_vld <= issue;
          ev_idx <= rp[AW-1:0];
          if (issue) rp <= rp + CW'(1);
          if (ev_vld) begin
            cum <= cum_sat;
            if (ev_idx == ridx) begin
              entry_value_us   <= val_q;
              entry_count      <= cnt_q;
              cumulative_count <= cum_sat;
              index_valid      <= 1'b1;
              state            <= S_OUT;
            end
          end
        end
        S_OUT: begin
          done <= 1'b1;
          if (rec) begin
            if (job_total != '1) job_total <= job_total + 32'd1;
            if (is_late && (late_total != '1)) late_total <= late_total + 32'd1;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    entries_used <= CW'(TABLE_DEPTH))
    else $error("table fill beyond depth");
  a_used_step: assert property (@(posedge clk) disable iff (rst)
    entries_used != $past(entries_used) |-> entries_used == $past(entries_used) + CW'(1))
    else $error("table fill moved by more than one");
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (done && dropped) |-> entries_used == CW'(TABLE_DEPTH))
    else $error("value dropped while table not full");
  a_read_fields: assert property (@(posedge clk) disable iff (rst)
    (done && !rec) |-> (!is_late && !dropped && response_us == '0))
    else $error("record fields set on a read");

endmodule
`default_nettype wire

@@ tb/job_deadline_response_histogram_core_test.sv @@
// testbench for the job deadline response histogram core: queued items, predictor, result check
`timescale 1ns / 1ps
`default_nettype none
module job_deadline_response_histogram_core_test;

  localparam int DEPTH = 1024;
  localparam longint unsigned CYCLE_LIMIT = 12000000;
  localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {ACT_JOB, ACT_CFG, ACT_DRAIN} act_kind_t;

  typedef struct {
    act_kind_t                  kind;
    logic                       slow;
    logic                       op;
    jdrh_pkg::time_ns_t         t_start;
    jdrh_pkg::time_ns_t         end_ns;
    logic [jdrh_pkg::IDX_W-1:0] idx;
    logic [jdrh_pkg::CFG_W-1:0] reg_sel;
    jdrh_pkg::time_ns_t         reg_val;
  } action_t;

  typedef struct {
    logic               late;
    jdrh_pkg::time_us_t resp;
    jdrh_pkg::count_t   late_cnt;
    jdrh_pkg::count_t   job_cnt;
    logic [10:0]        used;
    logic               drop;
    jdrh_pkg::time_us_t ent_val;
    jdrh_pkg::count_t   ent_cnt;
    jdrh_pkg::count_t   cum;
    logic               ivalid;
  } hist_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic cmd = 1'b0;
  jdrh_pkg::time_ns_t start_ns = '0;
  jdrh_pkg::time_ns_t finish_ns = '0;
  logic [jdrh_pkg::IDX_W-1:0] read_index = '0;
  logic cfg_valid = 1'b0;
  logic [jdrh_pkg::CFG_W-1:0] cfg_index = '0;
  jdrh_pkg::time_ns_t cfg_data = '0;
  wire busy, cfg_ready, done, is_late, dropped, index_valid;
  wire [jdrh_pkg::US_W-1:0] response_us, entry_value_us;
  wire [jdrh_pkg::CNT_W-1:0] late_total, job_total, entry_count, cumulative_count;
  wire [10:0] entries_used;

  job_deadline_response_histogram_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .start_ns(start_ns), .finish_ns(finish_ns), .read_index(read_index),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .is_late(is_late), .response_us(response_us),
    .late_total(late_total), .job_total(job_total), .entries_used(entries_used),
    .dropped(dropped), .entry_value_us(entry_value_us), .entry_count(entry_count),
    .cumulative_count(cumulative_count), .index_valid(index_valid)
  );

  // predictor state
  jdrh_pkg::time_ns_t m_period, m_rel_dl, m_ref, m_offset;
  jdrh_pkg::count_t   m_first;
  jdrh_pkg::time_us_t bucket_val [DEPTH];
  jdrh_pkg::count_t   bucket_cnt [DEPTH];
  int                 n_used;
  jdrh_pkg::count_t   n_jobs, n_late;

  action_t      pending_items [$];
  hist_result_t expected_results [$];
  int errors = 0;
  bit all_sent = 0;
  longint unsigned cycles = 0;

  // generation-side copy of the start reference and offset settings
  jdrh_pkg::time_ns_t g_ref, g_offset;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic jdrh_pkg::count_t inc_sat(jdrh_pkg::count_t v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic jdrh_pkg::time_ns_t add_sat(jdrh_pkg::time_ns_t a,
                                                 jdrh_pkg::time_ns_t b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? ALL1 : s[63:0];
  endfunction

  task automatic apply_setting(logic [jdrh_pkg::CFG_W-1:0] sel, jdrh_pkg::time_ns_t val);
    case (sel)
      jdrh_pkg::CFG_PERIOD:    m_period = val;
      jdrh_pkg::CFG_REL_DL:    m_rel_dl = val;
      jdrh_pkg::CFG_START_REF: m_ref = val;
      jdrh_pkg::CFG_OFFSET:    m_offset = val;
      jdrh_pkg::CFG_FIRST_JOB: m_first = val[31:0];
      default: ;
    endcase
  endtask

  task automatic predict_outcome(action_t a);
    hist_result_t r;
    logic [63:0] jobno, mult, rel, dl, frel, resp_ns;
    logic [127:0] prod;
    logic [54:0] us;
    logic [32:0] acc;
    int pos;
    r = '{default: '0};
    if (a.op == jdrh_pkg::CMD_RECORD) begin
      jobno = {32'd0, m_first} + {32'd0, n_jobs};
      mult = (jobno == 64'd0) ? 64'd0 : jobno - 64'd1;
      prod = {64'd0, m_period} * {64'd0, mult};
      rel = add_sat(m_offset, (prod[127:64] != 64'd0) ? ALL1 : prod[63:0]);
      dl = add_sat(rel, m_rel_dl);
      resp_ns = 64'd0;
      if (a.end_ns >= m_ref) begin
        frel = a.end_ns - m_ref;
        r.late = frel > dl;
        if (frel > rel) resp_ns = frel - rel;
      end
      us = 55'(resp_ns / 64'd1000);
      if (resp_ns % 64'd1000 >= 64'd500) us = us + 55'd1;
      r.resp = us;
      if (r.late) n_late = inc_sat(n_late);
      pos = 0;
      while (pos < n_used && bucket_val[pos] < us) pos++;
      if (pos < n_used && bucket_val[pos] == us) begin
        bucket_cnt[pos] = inc_sat(bucket_cnt[pos]);
      end else if (n_used >= DEPTH) begin
        r.drop = 1'b1;
      end else begin
        for (int k = n_used; k > pos; k--) begin
          bucket_val[k] = bucket_val[k-1];
          bucket_cnt[k] = bucket_cnt[k-1];
        end
        bucket_val[pos] = us;
        bucket_cnt[pos] = 32'd1;
        n_used++;
      end
      n_jobs = inc_sat(n_jobs);
    end else if (int'(a.idx) < n_used) begin
      acc = 33'd0;
      for (int k = 0; k <= int'(a.idx); k++) begin
        acc = acc + {1'b0, bucket_cnt[k]};
        if (acc[32]) acc = 33'h0_FFFF_FFFF;
      end
      r.ent_val = bucket_val[a.idx];
      r.ent_cnt = bucket_cnt[a.idx];
      r.cum = acc[31:0];
      r.ivalid = 1'b1;
    end
    r.late_cnt = n_late;
    r.job_cnt = n_jobs;
    r.used = 11'(n_used);
    expected_results.push_back(r);
  endtask

  // driver
  action_t cur;
  bit have_cur = 0, draining = 0;
  int gap = 0, settle = 0;
  always @(posedge clk) begin
    logic nstart, ncfg;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      have_cur = 0;
      draining = 0;
    end else begin
      nstart = start;
      ncfg = cfg_valid;
      if (start && !busy) begin
        predict_outcome(cur);
        nstart = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        apply_setting(cfg_index, cfg_data);
        ncfg = 1'b0;
      end
      if (!nstart && !ncfg) begin
        if (have_cur) begin
          if (gap > 0) begin
            gap--;
          end else begin
            have_cur = 0;
            if (cur.kind == ACT_JOB) begin
              nstart = 1'b1;
              cmd <= cur.op;
              start_ns <= cur.t_start;
              finish_ns <= cur.end_ns;
              read_index <= cur.idx;
            end else begin
              ncfg = 1'b1;
              cfg_index <= cur.reg_sel;
              cfg_data <= cur.reg_val;
            end
          end
        end else if (draining) begin
          if (expected_results.size() == 0 && !busy && !done) begin
            if (settle > 0) settle--;
            else draining = 0;
          end
        end else if (pending_items.size() > 0) begin
          cur = pending_items.pop_front();
          if (cur.kind == ACT_DRAIN) begin
            draining = 1;
            settle = 16;
          end else begin
            have_cur = 1;
            if (cur.slow || $urandom_range(0, 3) == 0) gap = int'($urandom_range(0, 11));
            else gap = 0;
          end
        end else begin
          all_sent = 1;
        end
      end
      start <= nstart;
      cfg_valid <= ncfg;
    end
  end

  // monitor
  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    hist_result_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result, expected none, actual response %0d", $time,
                 response_us);
        errors++;
      end else begin
        e = expected_results.pop_front();
        check_field("is_late", 64'(e.late), 64'(is_late));
        check_field("response_us", 64'(e.resp), 64'(response_us));
        check_field("late_total", 64'(e.late_cnt), 64'(late_total));
        check_field("job_total", 64'(e.job_cnt), 64'(job_total));
        check_field("entries_used", 64'(e.used), 64'(entries_used));
        check_field("dropped", 64'(e.drop), 64'(dropped));
        check_field("entry_value_us", 64'(e.ent_val), 64'(entry_value_us));
        check_field("entry_count", 64'(e.ent_cnt), 64'(entry_count));
        check_field("cumulative_count", 64'(e.cum), 64'(cumulative_count));
        check_field("index_valid", 64'(e.ivalid), 64'(index_valid));
      end
    end
  end

  function automatic jdrh_pkg::time_ns_t rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic add_job(logic op, jdrh_pkg::time_ns_t fin,
                         logic [jdrh_pkg::IDX_W-1:0] idx, logic slow);
    action_t a;
    a = '{kind: ACT_JOB, slow: slow, op: op, t_start: rnd64(), end_ns: fin, idx: idx,
          reg_sel: '0, reg_val: '0};
    pending_items.push_back(a);
  endtask

  task automatic add_setting(logic [jdrh_pkg::CFG_W-1:0] sel, jdrh_pkg::time_ns_t val);
    action_t a;
    a = '{kind: ACT_CFG, slow: 1'b1, op: 1'b0, t_start: '0, end_ns: '0, idx: '0,
          reg_sel: sel, reg_val: val};
    pending_items.push_back(a);
    if (sel == jdrh_pkg::CFG_START_REF) g_ref = val;
    if (sel == jdrh_pkg::CFG_OFFSET) g_offset = val;
  endtask

  task automatic add_drain();
    action_t a;
    a = '{kind: ACT_DRAIN, slow: 1'b0, op: 1'b0, t_start: '0, end_ns: '0, idx: '0,
          reg_sel: '0, reg_val: '0};
    pending_items.push_back(a);
  endtask

  function automatic jdrh_pkg::time_ns_t pick_setting(int unsigned span);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return ALL1;
      default: return jdrh_pkg::time_ns_t'($urandom_range(0, span));
    endcase
  endfunction

  initial begin
    jdrh_pkg::time_ns_t fin;
    logic slow;
    m_period = '0; m_rel_dl = '0; m_ref = '0; m_offset = '0; m_first = 32'd1;
    n_used = 0; n_jobs = '0; n_late = '0;
    g_ref = '0; g_offset = '0;

    // directed: empty reads, rounding edges, extremes
    add_job(jdrh_pkg::CMD_READ, 64'd0, 10'd0, 1'b1);
    add_job(jdrh_pkg::CMD_READ, ALL1, 10'd1023, 1'b1);
    add_job(jdrh_pkg::CMD_RECORD, 64'd0, 10'd0, 1'b1);
    add_job(jdrh_pkg::CMD_RECORD, 64'd499, 10'd0, 1'b0);
    add_job(jdrh_pkg::CMD_RECORD, 64'd500, 10'd0, 1'b0);
    add_job(jdrh_pkg::CMD_RECORD, 64'd1499, 10'd0, 1'b1);
    add_job(jdrh_pkg::CMD_RECORD, ALL1, 10'd1023, 1'b1);
    add_job(jdrh_pkg::CMD_READ, 64'd0, 10'd0, 1'b0);
    add_job(jdrh_pkg::CMD_READ, 64'd0, 10'd2, 1'b0);
    add_job(jdrh_pkg::CMD_READ, 64'd0, 10'd3, 1'b1);
    add_job(jdrh_pkg::CMD_READ, 64'd0, 10'd4, 1'b1);
    add_drain();
    add_setting(jdrh_pkg::CFG_START_REF, 64'd5000);
    add_setting(jdrh_pkg::CFG_PERIOD, 64'd1000);
    add_setting(jdrh_pkg::CFG_OFFSET, 64'd200);
    add_setting(jdrh_pkg::CFG_REL_DL, 64'd700);
    add_setting(jdrh_pkg::CFG_FIRST_JOB, 64'd0);
    add_job(jdrh_pkg::CMD_RECORD, 64'd2000, 10'd0, 1'b1);
    add_job(jdrh_pkg::CMD_RECORD, 64'd6500, 10'd0, 1'b1);
    add_job(jdrh_pkg::CMD_RECORD, 64'd7100, 10'd0, 1'b0);
    add_drain();
    add_setting(jdrh_pkg::CFG_PERIOD, ALL1);
    add_setting(jdrh_pkg::CFG_OFFSET, ALL1);
    add_setting(jdrh_pkg::CFG_REL_DL, ALL1);
    add_setting(jdrh_pkg::CFG_FIRST_JOB, 64'hFFFF_FFFF);
    add_job(jdrh_pkg::CMD_RECORD, ALL1, 10'd0, 1'b1);
    add_job(jdrh_pkg::CMD_RECORD, 64'd123456789, 10'd0, 1'b1);
    add_job(jdrh_pkg::CMD_READ, 64'd0, 10'd1, 1'b1);
    add_job(jdrh_pkg::CMD_READ, 64'd0, 10'd5, 1'b0);

    // random phases with new settings each time
    for (int ph = 0; ph < 11; ph++) begin
      slow = (ph % 3 != 2);
      add_drain();
      add_setting(jdrh_pkg::CFG_PERIOD, pick_setting(3000));
      add_setting(jdrh_pkg::CFG_REL_DL, pick_setting(80000));
      add_setting(jdrh_pkg::CFG_START_REF, pick_setting(100000));
      add_setting(jdrh_pkg::CFG_OFFSET, pick_setting(50000));
      case ($urandom_range(0, 3))
        0: add_setting(jdrh_pkg::CFG_FIRST_JOB, 64'd0);
        1: add_setting(jdrh_pkg::CFG_FIRST_JOB, 64'hFFFF_FFFF);
        2: add_setting(jdrh_pkg::CFG_FIRST_JOB, 64'd1);
        default: add_setting(jdrh_pkg::CFG_FIRST_JOB, jdrh_pkg::time_ns_t'($urandom));
      endcase
      for (int i = 0; i < 48; i++) begin
        if (ph == 5 && i == 25) add_drain();
        if ($urandom_range(0, 3) == 0) begin
          add_job(jdrh_pkg::CMD_READ, rnd64(),
                  ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40)),
                  slow);
        end else begin
          case ($urandom_range(0, 9))
            0, 1: fin = rnd64();
            2: fin = jdrh_pkg::time_ns_t'($urandom_range(0, 100000));
            default: fin = g_ref + g_offset
                           + jdrh_pkg::time_ns_t'($urandom_range(0, 60) * 1000)
                           + jdrh_pkg::time_ns_t'($urandom_range(0, 999));
          endcase
          add_job(jdrh_pkg::CMD_RECORD, fin, 10'($urandom), slow);
        end
      end
    end

    // plain settings, reads near the end of the table and a few more records
    add_drain();
    add_setting(jdrh_pkg::CFG_PERIOD, 64'd0);
    add_setting(jdrh_pkg::CFG_REL_DL, 64'd0);
    add_setting(jdrh_pkg::CFG_START_REF, 64'd0);
    add_setting(jdrh_pkg::CFG_OFFSET, 64'd0);
    add_setting(jdrh_pkg::CFG_FIRST_JOB, 64'd1);
    add_job(jdrh_pkg::CMD_READ, 64'd0, 10'd1023, 1'b1);
    add_job(jdrh_pkg::CMD_READ, 64'd0, 10'd1022, 1'b1);
    add_job(jdrh_pkg::CMD_READ, 64'd0, 10'd0, 1'b0);
    add_job(jdrh_pkg::CMD_READ, 64'd0, 10'd512, 1'b1);
    for (int i = 0; i < 6; i++)
      add_job(jdrh_pkg::CMD_RECORD,
              jdrh_pkg::time_ns_t'($urandom_range(0, 1200)) * 64'd1000,
              10'($urandom), 1'b1);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (!(all_sent && expected_results.size() == 0)) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
src/jdrh_pkg.sv
src/jdrh_timing.sv
src/job_deadline_response_histogram_core.sv
tb/job_deadline_response_histogram_core_test.sv
